FILE: src/etg_pkg.sv
// shared types, constants and helpers for the escape-time greyscale pixel core
package etg_pkg;

  // fixed-point format and index width
  localparam int FRAC_BITS  = 28;
  localparam int INDEX_BITS = 12;

  // escape threshold 4.0 at full product width, if it fits in 63 bits
  localparam bit              CAN_ESCAPE = (2 * FRAC_BITS + 2) <= 63;
  localparam logic [64:0]     ESC_THRESH = CAN_ESCAPE ? (65'd1 << (2 * FRAC_BITS + 2)) : 65'd0;
  localparam logic [11:0]     IDX_MASK   = 12'((64'd1 << INDEX_BITS) - 64'd1);

  // 255^2 * 4, scale of the grey comparison
  localparam logic signed [31:0] GREY_RHS_K = 32'sd260100;

  // apb address width and register map
  localparam int ADDR_BITS = 5;

  typedef enum logic [2:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_LIMIT    = 3'd4
  } reg_idx_t;

  // register reset values
  localparam logic signed [31:0] RST_X_ORIGIN = -32'sd563714458;
  localparam logic signed [31:0] RST_Y_ORIGIN = -32'sd322122547;
  localparam logic [30:0]        RST_X_STEP   = 31'd1207960;
  localparam logic [30:0]        RST_Y_STEP   = 31'd1610613;
  localparam logic [15:0]        RST_LIMIT    = 16'd200;

  // payload words
  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } pix_t;

  typedef struct packed {
    logic [7:0]  grey;
    logic [15:0] escape_count;
  } res_t;

  // configuration seen by the sequencer
  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [30:0]        x_step;
    logic [30:0]        y_step;
    logic [15:0]        iteration_limit;
  } cfg_t;

  // operands and products of the shared multiply unit
  typedef struct packed {
    logic signed [31:0] a0;
    logic signed [31:0] b0;
    logic signed [31:0] a1;
    logic signed [31:0] b1;
    logic signed [31:0] a2;
    logic signed [31:0] b2;
  } mul_op_t;

  typedef struct packed {
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
  } mul_res_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMUL,
    ST_CADD,
    ST_ITER,
    ST_UPD,
    ST_GRHS,
    ST_GINIT,
    ST_GSQ,
    ST_GLIM,
    ST_GCMP,
    ST_DONE
  } state_t;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      return 32'sh7fff_ffff;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

FILE: src/etg_cfg.sv
// apb configuration registers
module etg_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [etg_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output etg_pkg::cfg_t                 cfg
);
  import etg_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin        <= RST_X_ORIGIN;
      cfg.y_origin        <= RST_Y_ORIGIN;
      cfg.x_step          <= RST_X_STEP;
      cfg.y_step          <= RST_Y_STEP;
      cfg.iteration_limit <= RST_LIMIT;
    end else if (wr_en) begin
      unique case (idx)
        REG_X_ORIGIN: cfg.x_origin        <= pwdata;
        REG_Y_ORIGIN: cfg.y_origin        <= pwdata;
        REG_X_STEP:   cfg.x_step          <= pwdata[30:0];
        REG_Y_STEP:   cfg.y_step          <= pwdata[30:0];
        REG_LIMIT:    cfg.iteration_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    unique case (idx)
      REG_X_ORIGIN: prdata = cfg.x_origin;
      REG_Y_ORIGIN: prdata = cfg.y_origin;
      REG_X_STEP:   prdata = {1'b0, cfg.x_step};
      REG_Y_STEP:   prdata = {1'b0, cfg.y_step};
      REG_LIMIT:    prdata = {16'd0, cfg.iteration_limit};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

FILE: src/etg_mul.sv
// shared multiply unit: three signed 32x32 products, registered
module etg_mul (
  input  logic              clk,
  input  etg_pkg::mul_op_t  op,
  output etg_pkg::mul_res_t res
);
  import etg_pkg::*;

  // one multiplier per lane, result registered
  always_ff @(posedge clk) begin
    res.p0 <= 64'(op.a0) * 64'(op.b0);
    res.p1 <= 64'(op.a1) * 64'(op.b1);
    res.p2 <= 64'(op.a2) * 64'(op.b2);
  end

endmodule

FILE: src/etg_seq.sv
// sequencer: point setup, escape iteration and grey search over the shared multipliers
module etg_seq (
  input  logic              clk,
  input  logic              rst,
  input  etg_pkg::cfg_t     cfg,
  input  etg_pkg::pix_t     pix,
  input  logic              pix_valid,
  output logic              pix_ready,
  output etg_pkg::res_t     res,
  output logic              res_valid,
  input  logic              res_ready,
  output etg_pkg::mul_op_t  mul_op,
  input  etg_pkg::mul_res_t mul_res
);
  import etg_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [11:0]        col;
  logic [11:0]        row;
  logic signed [31:0] cre;
  logic signed [31:0] cim;
  logic signed [31:0] re;
  logic signed [31:0] im;
  logic [15:0]        iter;
  logic [15:0]        count;
  logic [34:0]        rhs;
  logic [7:0]         best;
  logic [2:0]         bit_idx;

  logic signed [31:0] cre_sat;
  logic signed [31:0] cim_sat;
  logic signed [63:0] rr;
  logic signed [63:0] ii;
  logic signed [63:0] ri;
  logic signed [31:0] re_upd;
  logic signed [31:0] im_upd;
  logic [64:0]        sq_sum;
  logic               escape;
  logic               at_limit;
  logic [7:0]         cand;
  logic [8:0]         k;
  logic               fits;
  logic               out_free;

  assign pix_ready = (state == ST_IDLE);
  assign out_free  = !res_valid || res_ready;

  // point forming from the index products
  assign cre_sat = sat32(66'(cfg.x_origin) + 66'(mul_res.p0));
  assign cim_sat = sat32(66'(cfg.y_origin) + 66'(mul_res.p1));

  // escape test and z update from the square products
  assign sq_sum   = {1'b0, mul_res.p0} + {1'b0, mul_res.p1};
  assign escape   = CAN_ESCAPE && (sq_sum > ESC_THRESH);
  assign rr       = mul_res.p0 >>> FRAC_BITS;
  assign ii       = mul_res.p1 >>> FRAC_BITS;
  assign ri       = mul_res.p2 >>> FRAC_BITS;
  assign re_upd   = sat32(66'(rr) - 66'(ii) + 66'(cre));
  assign im_upd   = sat32(66'(ri) + 66'(ri) + 66'(cim));
  assign at_limit = (iter == cfg.iteration_limit);

  // grey search candidate, one bit per round from the top
  assign cand = best | (8'd1 << bit_idx);
  assign k    = {cand, 1'b0} - 9'd1;
  assign fits = $unsigned(mul_res.p0) <= 64'(rhs);

  // next state and multiplier operand select
  always_comb begin
    state_next = state;
    mul_op     = '0;
    unique case (state)
      ST_IDLE: begin
        if (pix_valid) begin
          state_next = ST_CMUL;
        end
      end
      ST_CMUL: begin
        mul_op.a0  = $signed({20'd0, col});
        mul_op.b0  = $signed({1'b0, cfg.x_step});
        mul_op.a1  = $signed({20'd0, row});
        mul_op.b1  = $signed({1'b0, cfg.y_step});
        state_next = ST_CADD;
      end
      ST_CADD: begin
        state_next = ST_ITER;
      end
      ST_ITER: begin
        mul_op.a0 = re;
        mul_op.b0 = re;
        mul_op.a1 = im;
        mul_op.b1 = im;
        mul_op.a2 = re;
        mul_op.b2 = im;
        if (at_limit) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        if (escape) begin
          state_next = ST_GRHS;
        end else begin
          state_next = ST_ITER;
        end
      end
      ST_GRHS: begin
        mul_op.a0  = $signed({16'd0, count});
        mul_op.b0  = GREY_RHS_K;
        state_next = ST_GINIT;
      end
      ST_GINIT: begin
        state_next = ST_GSQ;
      end
      ST_GSQ: begin
        mul_op.a0  = $signed({23'd0, k});
        mul_op.b0  = $signed({23'd0, k});
        state_next = ST_GLIM;
      end
      ST_GLIM: begin
        mul_op.a0  = mul_res.p0[31:0];
        mul_op.b0  = $signed({16'd0, cfg.iteration_limit});
        state_next = ST_GCMP;
      end
      ST_GCMP: begin
        if (bit_idx == 3'd0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_GSQ;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      res.grey         <= best;
      res.escape_count <= count;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (pix_valid) begin
          col <= pix.column & IDX_MASK;
          row <= pix.row & IDX_MASK;
        end
      end
      ST_CADD: begin
        cre  <= cre_sat;
        cim  <= cim_sat;
        re   <= cre_sat;
        im   <= cim_sat;
        iter <= 16'd0;
      end
      ST_ITER: begin
        if (at_limit) begin
          count <= iter;
          best  <= 8'd0;
        end
      end
      ST_UPD: begin
        if (escape) begin
          count <= iter;
        end else begin
          re   <= re_upd;
          im   <= im_upd;
          iter <= iter + 16'd1;
        end
      end
      ST_GINIT: begin
        rhs     <= mul_res.p0[34:0];
        best    <= 8'd0;
        bit_idx <= 3'd7;
      end
      ST_GCMP: begin
        if (fits) begin
          best <= cand;
        end
        bit_idx <= bit_idx - 3'd1;
      end
      default: ;
    endcase
  end

endmodule

FILE: src/escape_time_greyscale_pixel_core.sv
// escape-time greyscale pixel core: each point iterates until it escapes or reaches the limit;
// an escaped point then takes the grey search, and a point at the limit gets grey 0
// one pixel at a time: each iteration is ITER then UPD around one pass through the shared
// multiply unit, and the grey search is GRHS and GINIT, then eight rounds of GSQ, GLIM and GCMP
// next word taken the cycle after the result is loaded, even while it waits in the output register
// synchronous reset returns the sequencer to idle, clears the output valid, loads default registers
module escape_time_greyscale_pixel_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [etg_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  etg_pkg::pix_t                 pix,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  output etg_pkg::res_t                 res,
  output logic                          res_valid,
  input  logic                          res_ready
);
  import etg_pkg::*;

  cfg_t     cfg;
  mul_op_t  mul_op;
  mul_res_t mul_res;

  // configuration registers
  etg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // shared multiply unit
  etg_mul u_mul (
    .clk (clk),
    .op  (mul_op),
    .res (mul_res)
  );

  // sequencer
  etg_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix       (pix),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .mul_op    (mul_op),
    .mul_res   (mul_res)
  );

endmodule

FILE: bench/escape_time_greyscale_pixel_core_test.sv
// self-checking bench for the escape-time greyscale pixel core: apb set-up, pixel words, result check
module escape_time_greyscale_pixel_core_test;
  import etg_pkg::*;

  localparam int unsigned PIXEL_TOTAL = 1950;
  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam logic [2:0]  SPARE_REG_FIRST = 3'd5;
  localparam logic [2:0]  SPARE_REG_LAST  = 3'd7;

  // expected results per pixel, with a private copy of the register file
  class pixel_scoreboard;
    localparam int         FRAC = 28;
    localparam logic [63:0] ESCAPE_LEVEL = 64'd1 << (2 * FRAC + 2);

    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [30:0]        x_step;
    logic [30:0]        y_step;
    logic [15:0]        iteration_limit;
    res_t               due[$];
    int unsigned        seen;
    int unsigned        errors;

    function new();
      x_origin        = -32'sd563714458;
      y_origin        = -32'sd322122547;
      x_step          = 31'd1207960;
      y_step          = 31'd1610613;
      iteration_limit = 16'd200;
      seen            = 0;
      errors          = 0;
    endfunction

    // register write as the block sees it; spare addresses do nothing
    function void load_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_X_ORIGIN: x_origin = v;
        REG_Y_ORIGIN: y_origin = v;
        REG_X_STEP:   x_step = v[30:0];
        REG_Y_STEP:   y_step = v[30:0];
        REG_LIMIT:    iteration_limit = v[15:0];
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // z = z*z + c from z = c, counting until |z|^2 > 4 or the limit
    function logic [15:0] escape_count_for(logic signed [31:0] cre, logic signed [31:0] cim);
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic signed [63:0] wre;
      logic signed [63:0] wim;
      logic signed [63:0] rr;
      logic signed [63:0] ii;
      logic signed [63:0] ri;
      logic [63:0]        sq_re;
      logic [63:0]        sq_im;
      int unsigned        n;
      re = cre;
      im = cim;
      for (n = 0; n < iteration_limit; n++) begin
        wre   = re;
        wim   = im;
        sq_re = wre * wre;
        sq_im = wim * wim;
        if (sq_re + sq_im > ESCAPE_LEVEL) return 16'(n);
        rr = sq_re >> FRAC;
        ii = sq_im >> FRAC;
        ri = (wre * wim) >>> FRAC;
        re = clamp32(rr - ii + cre);
        im = clamp32(2 * ri + cim);
      end
      return iteration_limit;
    endfunction

    // largest r with (2r-1)^2 * limit <= 260100 * count, black when the limit is hit
    function logic [7:0] grey_for(logic [15:0] count);
      logic [63:0] k;
      logic [63:0] rhs;
      logic [7:0]  best;
      int          r;
      best = 8'd0;
      rhs  = 64'd260100 * 64'(count);
      if (count == iteration_limit) return 8'd0;
      for (r = 1; r <= 255; r++) begin
        k = 64'(2 * r - 1);
        if (k * k * 64'(iteration_limit) <= rhs) best = 8'(r);
      end
      return best;
    endfunction

    function void note_pixel(pix_t p);
      logic signed [63:0] re_w;
      logic signed [63:0] im_w;
      res_t               want;
      re_w = x_origin;
      im_w = y_origin;
      re_w = re_w + $signed(64'(p.column) * 64'(x_step));
      im_w = im_w + $signed(64'(p.row) * 64'(y_step));
      want.escape_count = escape_count_for(clamp32(re_w), clamp32(im_w));
      want.grey         = grey_for(want.escape_count);
      due.push_back(want);
    endfunction

    task flag(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      seen++;
      if (due.size() == 0) begin
        flag($sformatf("unexpected result grey %0d count %0d", got.grey, got.escape_count));
        return;
      end
      want = due.pop_front();
      if (got.grey !== want.grey)
        flag($sformatf("grey %0d, expected %0d (count %0d)",
                       got.grey, want.grey, want.escape_count));
      if (got.escape_count !== want.escape_count)
        flag($sformatf("escape count %0d, expected %0d", got.escape_count, want.escape_count));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  pix_t                 pix;
  logic                 pix_valid;
  logic                 pix_ready;
  res_t                 res;
  logic                 res_valid;
  logic                 res_ready;

  pixel_scoreboard sb = new();
  bit              calm;
  int unsigned     sent;
  int unsigned     hold_left;
  int unsigned     cycles;

  escape_time_greyscale_pixel_core dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pix       (pix),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  always #5 clk = ~clk;

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 200);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_left <= pick_gap();
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_valid && pix_ready) sb.note_pixel(pix);
      if (res_valid && res_ready) sb.check_result(res);
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // apb write: setup cycle, then access cycle
  task write_reg(input logic [2:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.load_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // full register set, with junk above the narrow registers
  task apply_config(input logic signed [31:0] xo, input logic signed [31:0] yo,
                    input logic [30:0] xs, input logic [30:0] ys, input logic [15:0] lim);
    write_reg(REG_X_ORIGIN, xo);
    write_reg(REG_Y_ORIGIN, yo);
    write_reg(REG_X_STEP, {1'($urandom), xs});
    write_reg(REG_Y_STEP, {1'($urandom), ys});
    write_reg(REG_LIMIT, {16'($urandom), lim});
  endtask

  // one pixel word; valid stays up across back-to-back words
  task send_pixel(input logic [11:0] col, input logic [11:0] row);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.column <= col;
    pix.row    <= row;
    pix_valid  <= 1'b1;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    sent++;
  endtask

  // wait for every result of the words sent so far
  task settle();
    pix_valid <= 1'b0;
    while (sb.seen < sent) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_index();
    case ($urandom_range(0, 9))
      0:       return 12'd0;
      1:       return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] pick_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return 31'($urandom_range(100000, 260000));
    if (r < 88) return 31'd0;
    if (r < 94) return 31'h7fff_ffff;
    return 31'($urandom);
  endfunction

  function automatic logic signed [31:0] pick_origin(input int unsigned span, input int base);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return int'($urandom_range(0, span)) + base;
    if (r < 88) return 32'sh7fff_ffff;
    if (r < 94) return 32'sh8000_0000;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom_range(0, 3));
    if (r < 45) return 16'($urandom_range(4, 20));
    if (r < 80) return 16'($urandom_range(21, 64));
    if (r < 95) return 16'd200;
    return 16'($urandom_range(65, 400));
  endfunction

  initial begin
    int unsigned burst;
    logic [2:0]  spare;
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    pix       <= '0;
    pix_valid <= 1'b0;
    sent      = 0;
    calm      = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset registers: corners, main cardioid, near origin
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'd0, 12'hfff);
    send_pixel(12'hfff, 12'd0);
    send_pixel(12'd356, 12'd200);
    send_pixel(12'd356, 12'd199);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd466, 12'd200);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd2730, 12'd1365);
    send_pixel(12'd4094, 12'd1);
    settle();

    // zero limit: count and grey both zero
    write_reg(REG_LIMIT, 32'ha5a5_0000);
    send_pixel(12'd356, 12'd200);
    send_pixel(12'd0, 12'd0);
    settle();

    // limit of one: immediate escape versus reaching the limit
    write_reg(REG_LIMIT, 32'h0000_0001);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'd356, 12'd200);
    settle();

    // coordinates clamp at both ends, spare addresses must not disturb anything
    apply_config(32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff, 31'h7fff_ffff, 16'd3);
    for (spare = SPARE_REG_FIRST; spare != SPARE_REG_LAST; spare++)
      write_reg(spare, $urandom);
    write_reg(SPARE_REG_LAST, $urandom);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd2048);
    settle();

    // largest limit: c = 0 never escapes, c = 3 and c = 1 do
    apply_config(32'sd0, 32'sd0, 31'd1 << 28, 31'd0, 16'hffff);
    send_pixel(12'd0, 12'd5);
    send_pixel(12'd3, 12'd0);
    send_pixel(12'd1, 12'd7);
    settle();

    // random phases, each with its own register set
    while (sent < PIXEL_TOTAL) begin
      apply_config(pick_origin(805306368, -671088640), pick_origin(268435456, -402653184),
                   pick_step(), pick_step(), pick_limit());
      calm  = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(20, 120);
      repeat (burst) send_pixel(pick_index(), pick_index());
      settle();
    end

    calm = 1'b0;
    repeat (2 * sb.iteration_limit + 40) @(posedge clk);
    if (sb.due.size() != 0) sb.flag($sformatf("%0d results never arrived", sb.due.size()));
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/etg_pkg.sv
src/etg_cfg.sv
src/etg_mul.sv
src/etg_seq.sv
src/escape_time_greyscale_pixel_core.sv
bench/escape_time_greyscale_pixel_core_test.sv
